### rtl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; every other rtl file imports this package.
`default_nettype none
package lr_pkg;

  localparam int COORD_BITS   = 10;
  localparam int COLOR_W      = 4;
  localparam int ERR_W        = COORD_BITS + 3;
  localparam int CNT_W        = COORD_BITS + 1;
  localparam int IN_FIELDS_W  = 4 * COORD_BITS + COLOR_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COORD_BITS + COLOR_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_W-1:0]    color_t;

  typedef struct packed {
    logic   is_start;
    coord_t x0;
    coord_t y0;
    coord_t major;
    coord_t minor;
    logic   x_neg;
    logic   x_nz;
    logic   y_neg;
    logic   y_nz;
    logic   steep;
    color_t color;
  } line_cmd_t;

  function automatic coord_t step_coord(coord_t c, logic nz, logic neg);
    coord_t r;
    r = c;
    if (nz) begin
      r = neg ? (c - coord_t'(1)) : (c + coord_t'(1));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/lr_front.sv
// Front end: accepts input beats, decodes start/tick and precomputes line setup.
// Depends on lr_pkg.
`default_nettype none
module lr_front (
  input  wire logic                        in_tvalid,
  input  wire logic                        in_tready,
  input  wire logic [lr_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                        in_tuser,
  output logic                             push,
  output lr_pkg::line_cmd_t                cmd
);
  import lr_pkg::*;

  coord_t x0, y0, x1, y1;
  color_t color;
  logic [COORD_BITS:0] ddx, ddy;
  coord_t adx, ady;
  logic   steep;

  always_comb begin
    x0    = in_tdata[COORD_BITS-1:0];
    y0    = in_tdata[2*COORD_BITS-1:COORD_BITS];
    x1    = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
    y1    = in_tdata[4*COORD_BITS-1:3*COORD_BITS];
    color = in_tdata[4*COORD_BITS+COLOR_W-1:4*COORD_BITS];
    ddx   = {1'b0, x1} - {1'b0, x0};
    ddy   = {1'b0, y1} - {1'b0, y0};
    adx   = ddx[COORD_BITS] ? coord_t'(-ddx) : ddx[COORD_BITS-1:0];
    ady   = ddy[COORD_BITS] ? coord_t'(-ddy) : ddy[COORD_BITS-1:0];
    steep = ady > adx;

    cmd.is_start = (in_tuser == CMD_START);
    cmd.x0       = x0;
    cmd.y0       = y0;
    cmd.major    = steep ? ady : adx;
    cmd.minor    = steep ? adx : ady;
    cmd.x_neg    = ddx[COORD_BITS];
    cmd.x_nz     = (x1 != x0);
    cmd.y_neg    = ddy[COORD_BITS];
    cmd.y_nz     = (y1 != y0);
    cmd.steep    = steep;
    cmd.color    = color;
  end

  assign push = in_tvalid && in_tready;

endmodule
`default_nettype wire

### rtl/lr_fifo.sv
// Short command queue between front end and stepper.
// Depends on lr_pkg.
`default_nettype none
module lr_fifo (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire lr_pkg::line_cmd_t wr_cmd,
  input  wire logic        pop,
  output lr_pkg::line_cmd_t rd_cmd,
  output logic             full,
  output logic             not_empty
);
  import lr_pkg::*;

  line_cmd_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  assign rd_cmd    = mem[rd_ptr_r];
  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);

endmodule
`default_nettype wire

### rtl/lr_back.sv
// Stepper: runs the Bresenham recurrence and holds the output register.
// Depends on lr_pkg.
`default_nettype none
module lr_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lr_pkg::line_cmd_t            head,
  input  wire logic                         head_valid,
  output logic                              pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [lr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                              out_tlast
);
  import lr_pkg::*;

  coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  coord_t major_r, major_nxt, minor_r, minor_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic x_neg_r, x_neg_nxt, x_nz_r, x_nz_nxt;
  logic y_neg_r, y_neg_nxt, y_nz_r, y_nz_nxt;
  logic steep_r, steep_nxt;
  color_t color_r, color_nxt;

  logic   out_valid_r, out_valid_nxt;
  coord_t out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  color_t out_color_r, out_color_nxt;
  logic   out_last_r, out_last_nxt;

  logic out_free, emit, err_ge;
  logic signed [ERR_W-1:0] maj2, min2, init_err;

  always_comb begin
    out_free = !out_valid_r || out_tready;
    emit     = head_valid && !head.is_start && (left_r != '0) && out_free;
    pop      = head_valid && (head.is_start || (left_r == '0) || out_free);
    err_ge   = !err_r[ERR_W-1];
    maj2     = signed'({2'b00, major_r, 1'b0});
    min2     = signed'({2'b00, minor_r, 1'b0});
    init_err = signed'({2'b00, head.minor, 1'b0}) - signed'({3'b000, head.major});

    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    err_nxt   = err_r;
    left_nxt  = left_r;
    x_neg_nxt = x_neg_r;
    x_nz_nxt  = x_nz_r;
    y_neg_nxt = y_neg_r;
    y_nz_nxt  = y_nz_r;
    steep_nxt = steep_r;
    color_nxt = color_r;

    out_valid_nxt = out_valid_r && !out_tready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;

    if (head_valid && head.is_start) begin
      cur_x_nxt = head.x0;
      cur_y_nxt = head.y0;
      major_nxt = head.major;
      minor_nxt = head.minor;
      err_nxt   = init_err;
      left_nxt  = {1'b0, head.major};
      x_neg_nxt = head.x_neg;
      x_nz_nxt  = head.x_nz;
      y_neg_nxt = head.y_neg;
      y_nz_nxt  = head.y_nz;
      steep_nxt = head.steep;
      color_nxt = head.color;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = cur_x_r;
      out_y_nxt     = cur_y_r;
      out_color_nxt = color_r;
      out_last_nxt  = (left_r == CNT_W'(1));
      err_nxt       = err_r - (err_ge ? maj2 : '0) + min2;
      left_nxt      = left_r - CNT_W'(1);
      if (steep_r) begin
        cur_y_nxt = step_coord(cur_y_r, y_nz_r, y_neg_r);
        if (err_ge) begin
          cur_x_nxt = step_coord(cur_x_r, x_nz_r, x_neg_r);
        end
      end else begin
        cur_x_nxt = step_coord(cur_x_r, x_nz_r, x_neg_r);
        if (err_ge) begin
          cur_y_nxt = step_coord(cur_y_r, y_nz_r, y_neg_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      major_r     <= '0;
      minor_r     <= '0;
      err_r       <= '0;
      left_r      <= '0;
      x_neg_r     <= 1'b0;
      x_nz_r      <= 1'b0;
      y_neg_r     <= 1'b0;
      y_nz_r      <= 1'b0;
      steep_r     <= 1'b0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      err_r       <= err_nxt;
      left_r      <= left_nxt;
      x_neg_r     <= x_neg_nxt;
      x_nz_r      <= x_nz_nxt;
      y_neg_r     <= y_neg_nxt;
      y_nz_r      <= y_nz_nxt;
      steep_r     <= steep_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_color_r, out_y_r, out_x_r});
  assign out_tlast  = out_last_r;

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop with empty queue");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (left_r == $past(left_r) - CNT_W'(1)) && out_valid_r)
    else $error("pixel count did not step");

  a_err_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != '0) |-> ((err_r >= -maj2) && (err_r < min2 || min2 == maj2)))
    else $error("error term out of range");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && left_r == CNT_W'(1)) |=> (left_r == '0) && out_last_r)
    else $error("last pixel did not end the line");

endmodule
`default_nettype wire

### rtl/line_rasterizer_unit.sv
// Line rasterizer top level: front end, command queue and stepper.
// Depends on lr_pkg, lr_front, lr_fifo, lr_back.
//
// Usage:
//   Input channel in_*: each beat is a start (in_tuser low) carrying two
//   endpoints and a pen color, or a tick (in_tuser high). A start sets up a
//   new line and abandons any line in progress; it produces no output.
//   Each tick produces one pixel beat on out_* while pixels remain, and
//   nothing otherwise. A line yields max(|dx|,|dy|) pixels; the far endpoint
//   is not drawn. out_tlast marks the final pixel of a line.
//   Path: an accepted tick beat waits in the command queue, and its pixel is
//   then held in the output register. Throughput: one beat per cycle on both
//   channels while the queue is not full and out_tready is high; the stepper
//   updates its error term with one add/subtract per pixel.
//   Stalls: when out_tready is low the output register holds its beat, the
//   stepper pauses and the four-entry queue absorbs further input beats;
//   in_tready drops once the queue is full.
//   Reset (rst_n low, synchronous) empties the queue and output register
//   and clears the line state, so ticks give nothing until a start.
`default_nettype none
module line_rasterizer_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // start_x, start_y, end_x, end_y, pen_color, zero pad
  input  wire logic [lr_pkg::IN_DATA_W-1:0] in_tdata,
  // cmd
  input  wire logic                         in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [lr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                              out_tlast
);
  import lr_pkg::*;

  line_cmd_t front_cmd, head_cmd;
  logic push, pop, full, not_empty;

  assign in_tready = !full;

  lr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .cmd       (front_cmd)
  );

  lr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_cmd    (front_cmd),
    .pop       (pop),
    .rd_cmd    (head_cmd),
    .full      (full),
    .not_empty (not_empty)
  );

  lr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_cmd),
    .head_valid (not_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
